// ----- design/upd_pkg.sv -----
`timescale 1ns / 1ps

package upd_pkg;

	localparam int LIMIT_W          = 17;
	localparam int LENGTH_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF  = 4;
	localparam int SLOTS            = 3;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_PCT    = 2'd1,
		PH_DIGIT  = 2'd2
	} phase_t;

	// one accepted item after classification and limiting
	typedef struct packed {
		logic [SLOTS-1:0][7:0] bytes;
		logic [1:0]            nbytes;
		logic                  str_end;
		logic [LIMIT_W-1:0]    len;
	} upd_entry_t;

	// {valid, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			r = {1'b1, 4'(c - CH_ZERO)};
		end else if (c >= CH_LA && c <= CH_LF) begin
			r = {1'b1, 4'(c - CH_LA + HEX_TEN)};
		end else if (c >= CH_UA && c <= CH_UF) begin
			r = {1'b1, 4'(c - CH_UA + HEX_TEN)};
		end
		return r;
	endfunction

endpackage

// ----- design/upd_front.sv -----
`timescale 1ns / 1ps

module upd_front
	import upd_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LIMIT_W-1:0] cfg_wr_data,
	input  logic               accept,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	output logic               entry_push,
	output upd_entry_t         entry
);

	localparam logic [LIMIT_W:0] CAP = (LENGTH_BITS < LIMIT_W) ?
		((LIMIT_W+1)'(1) << LENGTH_BITS) : {1'b1, {LIMIT_W{1'b0}}};
	localparam logic [LIMIT_W-1:0] LIMIT_RST_CLIP = ({1'b0, LIMIT_RESET} < CAP) ?
		LIMIT_RESET : CAP[LIMIT_W-1:0];

	phase_t                 phase_q, phase_d;
	logic [7:0]             held_q, held_d;
	logic [LIMIT_W-1:0]     count_q, limit_q;
	logic [LIMIT_W-1:0]     cfg_clip, room, new_count;
	logic [SLOTS-1:0][7:0]  cand;
	logic [1:0]             n_cand, n_emit;
	logic [4:0]             hb, hh;
	logic                   ord;

	// the limit is clipped once, when it is written
	assign cfg_clip = ({1'b0, cfg_wr_data} < CAP) ? cfg_wr_data : CAP[LIMIT_W-1:0];

	always_comb begin
		hb      = hex_decode(in_byte);
		hh      = hex_decode(held_q);
		cand    = '0;
		n_cand  = 2'd0;
		phase_d = phase_q;
		held_d  = held_q;
		ord     = 1'b0;
		unique case (phase_q)
			PH_PCT: begin
				if (hb[4]) begin
					held_d  = in_byte;
					phase_d = PH_DIGIT;
				end else begin
					cand[n_cand] = CH_PCT;
					n_cand       = n_cand + 2'd1;
					ord          = 1'b1;
				end
			end
			PH_DIGIT: begin
				if (hb[4]) begin
					cand[0] = {hh[4] ? hh[3:0] : 4'd0, hb[3:0]};
					n_cand  = 2'd1;
					phase_d = PH_NORMAL;
				end else begin
					cand[0] = CH_PCT;
					cand[1] = held_q;
					n_cand  = 2'd2;
					ord     = 1'b1;
				end
			end
			default: ord = 1'b1;
		endcase
		if (ord) begin
			phase_d = PH_NORMAL;
			if (in_byte == CH_PLUS) begin
				cand[n_cand] = CH_SPACE;
				n_cand       = n_cand + 2'd1;
			end else if (in_byte == CH_PCT) begin
				phase_d = PH_PCT;
			end else begin
				cand[n_cand] = in_byte;
				n_cand       = n_cand + 2'd1;
			end
		end
		// escape cut off by the end of the string goes out literally
		if (in_last) begin
			if (phase_d == PH_PCT) begin
				cand[n_cand] = CH_PCT;
				n_cand       = n_cand + 2'd1;
			end else if (phase_d == PH_DIGIT) begin
				cand[n_cand] = CH_PCT;
				n_cand       = n_cand + 2'd1;
				cand[n_cand] = held_d;
				n_cand       = n_cand + 2'd1;
			end
			phase_d = PH_NORMAL;
			held_d  = 8'd0;
		end
	end

	// count may sit above a limit lowered mid-string
	assign room      = (count_q < limit_q) ? limit_q - count_q : '0;
	assign n_emit    = (room < LIMIT_W'(n_cand)) ? room[1:0] : n_cand;
	assign new_count = count_q + LIMIT_W'(n_emit);

	always_comb begin
		entry.bytes   = cand;
		entry.nbytes  = n_emit;
		entry.str_end = in_last;
		entry.len     = new_count;
	end

	assign entry_push = accept && (n_emit != 2'd0 || in_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 8'd0;
			count_q <= '0;
			limit_q <= LIMIT_RST_CLIP;
		end else begin
			if (accept) begin
				held_q  <= held_d;
				count_q <= in_last ? '0 : new_count;
			end
			if (cfg_wr_en) begin
				limit_q <= cfg_clip;
			end
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |=> count_q == '0 && phase_q == PH_NORMAL)
		else $error("count or phase not cleared after string end");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		accept && n_emit != 2'd0 |-> count_q < limit_q)
		else $error("byte emitted beyond output limit");

endmodule

// ----- design/upd_queue.sv -----
`timescale 1ns / 1ps

module upd_queue
	import upd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  upd_entry_t wr_entry,
	output logic       full,
	input  logic       pop,
	output upd_entry_t rd_entry,
	output logic       empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	upd_entry_t       mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("entry pushed into a full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count out of range");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && empty |=> !empty)
		else $error("pushed entry not visible");

endmodule

// ----- design/upd_back.sv -----
`timescale 1ns / 1ps

module upd_back
	import upd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  upd_entry_t         head,
	input  logic               q_empty,
	output logic               q_pop,
	input  logic               pop,
	output logic [7:0]         out_byte,
	output logic               has_byte,
	output logic               run_last,
	output logic               string_end,
	output logic [LIMIT_W-1:0] decoded_length
);

	logic [1:0] pos_q;
	logic [2:0] total;
	logic       is_byte, xfer;

	assign total   = {1'b0, head.nbytes} + {2'b00, head.str_end};
	assign is_byte = (pos_q < head.nbytes);
	assign xfer    = pop && !q_empty;

	always_comb begin
		case (pos_q)
			2'd0:    out_byte = is_byte ? head.bytes[0] : 8'd0;
			2'd1:    out_byte = is_byte ? head.bytes[1] : 8'd0;
			2'd2:    out_byte = is_byte ? head.bytes[2] : 8'd0;
			default: out_byte = 8'd0;
		endcase
	end

	assign has_byte       = is_byte;
	assign string_end     = !is_byte && head.str_end;
	assign decoded_length = string_end ? head.len : '0;
	assign run_last       = ({1'b0, pos_q} + 3'd1 == total);
	assign q_pop          = xfer && run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
		end else if (xfer) begin
			pos_q <= run_last ? 2'd0 : pos_q + 2'd1;
		end
	end

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (has_byte ^ string_end))
		else $error("result is neither a byte nor an end report");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty && string_end |-> run_last)
		else $error("end report is not the last result of its item");

endmodule

// ----- design/url_percent_decoder.sv -----
`timescale 1ns / 1ps

// URL percent decoder, one encoded byte per transfer.
// input side: a queue write port. in_byte/in_last transfer on a clock edge
// with push high and full low; in_last marks the final byte of a string.
// result side: a queue read port. while empty is low the oldest result is on
// out_byte/has_byte/run_last/string_end/decoded_length; pop with empty low
// takes it. run_last flags the last result caused by one input byte; the
// result with string_end high carries the decoded length of the string.
// config: cfg_wr_data, clipped to 2**LENGTH_BITS, is written into the output
// limit whenever cfg_wr_en is high; write it between strings.
// a result is registered in the entry queue before it can be taken.
// throughput: one input byte per cycle while each byte yields at most one
// result and pop stays high; a byte that yields n results holds the result
// side until all n are taken, one result per cycle while pop is high. the
// entry queue between front and back (QUEUE_DEPTH entries) absorbs that, and
// full rises only once it fills. if the receiver stalls, results wait in the
// queue and push is refused once it is full; nothing is dropped.
// reset: clears escape state, byte count and queue, and sets the output limit
// to 65536; no clearing pass, input may follow the first edge after reset.
module url_percent_decoder
	import upd_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LIMIT_W-1:0] cfg_wr_data,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         out_byte,
	output logic               has_byte,
	output logic               run_last,
	output logic               string_end,
	output logic [LIMIT_W-1:0] decoded_length
);

	upd_entry_t wr_entry, head;
	logic       entry_push, q_pop, q_empty, accept;

	assign accept = push && !full;
	assign empty  = q_empty;

	upd_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.accept     (accept),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.entry_push (entry_push),
		.entry      (wr_entry)
	);

	upd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (entry_push),
		.wr_entry(wr_entry),
		.full    (full),
		.pop     (q_pop),
		.rd_entry(head),
		.empty   (q_empty)
	);

	upd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.pop           (pop),
		.out_byte      (out_byte),
		.has_byte      (has_byte),
		.run_last      (run_last),
		.string_end    (string_end),
		.decoded_length(decoded_length)
	);

endmodule

// ----- dv/url_percent_decoder_tb.sv -----
`timescale 1ns / 1ps

module url_percent_decoder_tb;
	import upd_pkg::*;

	localparam int WATCHDOG_CYCLES = 5000;
	localparam int HOLD_CYCLES     = 60;
	localparam int TARGET_ITEMS    = 170;
	localparam logic [LIMIT_W-1:0] LEN_CAP = 17'd1 << LENGTH_BITS_DEF;

	typedef struct packed {
		logic [7:0]         ob;
		logic               hb;
		logic               rl;
		logic               se;
		logic [LIMIT_W-1:0] len;
	} dec_result_t;

	typedef struct {
		logic [7:0] b;
		logic       last;
		bit         typed;
		logic [7:0] eb;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [LIMIT_W-1:0] cfg_wr_data;
	logic               push;
	logic               full;
	logic [7:0]         in_byte;
	logic               in_last;
	logic               empty;
	logic               pop;
	logic [7:0]         out_byte;
	logic               has_byte;
	logic               run_last;
	logic               string_end;
	logic [LIMIT_W-1:0] decoded_length;

	url_percent_decoder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.push           (push),
		.full           (full),
		.in_byte        (in_byte),
		.in_last        (in_last),
		.empty          (empty),
		.pop            (pop),
		.out_byte       (out_byte),
		.has_byte       (has_byte),
		.run_last       (run_last),
		.string_end     (string_end),
		.decoded_length (decoded_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decoder shadow state
	phase_t             esc_ph;
	logic [7:0]         held;
	logic [LIMIT_W-1:0] emitted;
	logic [LIMIT_W-1:0] limit_q;

	dec_result_t step_out[$];
	dec_result_t pending_out[$];

	int  err_cnt;
	int  n_items;
	int  n_strings;
	int  n_results;
	int  n_cfg;
	int  n_full_stalls;
	bit  no_idle;
	bit  stall_req;

	// directed rows: plain bytes and extremes are typed in, escapes are predicted
	row_t dir_rows [26] = '{
		'{"a",     1'b0, 1'b1, "a"},
		'{CH_PLUS, 1'b0, 1'b1, CH_SPACE},
		'{8'h00,   1'b0, 1'b1, 8'h00},
		'{8'hFF,   1'b0, 1'b1, 8'hFF},
		'{CH_PCT,  1'b0, 1'b0, 8'h00},
		'{"4",     1'b0, 1'b0, 8'h00},
		'{"1",     1'b0, 1'b0, 8'h00},
		'{CH_PCT,  1'b0, 1'b0, 8'h00},
		'{"f",     1'b0, 1'b0, 8'h00},
		'{"F",     1'b0, 1'b0, 8'h00},
		'{CH_PCT,  1'b0, 1'b0, 8'h00},
		'{"G",     1'b0, 1'b0, 8'h00},
		'{CH_PCT,  1'b0, 1'b0, 8'h00},
		'{"3",     1'b0, 1'b0, 8'h00},
		'{CH_PCT,  1'b0, 1'b0, 8'h00},
		'{"4",     1'b0, 1'b0, 8'h00},
		'{"z",     1'b0, 1'b0, 8'h00},
		'{CH_PCT,  1'b1, 1'b0, 8'h00},
		'{CH_PCT,  1'b0, 1'b0, 8'h00},
		'{"a",     1'b1, 1'b0, 8'h00},
		'{"x",     1'b1, 1'b0, 8'h00},
		'{CH_PCT,  1'b0, 1'b0, 8'h00},
		'{CH_PLUS, 1'b0, 1'b0, 8'h00},
		'{CH_PCT,  1'b0, 1'b0, 8'h00},
		'{CH_PCT,  1'b0, 1'b0, 8'h00},
		'{"9",     1'b1, 1'b0, 8'h00}
	};

	function automatic int hex_val(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return int'(c) - int'("0");
		end
		if (c >= "a" && c <= "f") begin
			return int'(c) - int'("a") + 10;
		end
		if (c >= "A" && c <= "F") begin
			return int'(c) - int'("A") + 10;
		end
		return -1;
	endfunction

	function automatic logic [LIMIT_W-1:0] eff_limit();
		return (limit_q < LEN_CAP) ? limit_q : LEN_CAP;
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		dec_result_t r;
		if (emitted < eff_limit()) begin
			r = '0;
			r.ob = b;
			r.hb = 1'b1;
			step_out.push_back(r);
			emitted = emitted + 1'b1;
		end
	endfunction

	function automatic void feed_plain(input logic [7:0] b);
		if (b == CH_PLUS) begin
			put_byte(CH_SPACE);
		end else if (b == CH_PCT) begin
			esc_ph = PH_PCT;
		end else begin
			put_byte(b);
		end
	endfunction

	// results caused by one accepted byte, in order
	function automatic void decode_step(input logic [7:0] b, input logic l);
		int lo;
		int hi;
		dec_result_t r;
		step_out.delete();
		case (esc_ph)
			PH_PCT: begin
				if (hex_val(b) >= 0) begin
					held = b;
					esc_ph = PH_DIGIT;
				end else begin
					esc_ph = PH_NORMAL;
					put_byte(CH_PCT);
					feed_plain(b);
				end
			end
			PH_DIGIT: begin
				lo = hex_val(b);
				if (lo >= 0) begin
					hi = hex_val(held);
					if (hi < 0) hi = 0;
					esc_ph = PH_NORMAL;
					put_byte(8'((hi << 4) | lo));
				end else begin
					esc_ph = PH_NORMAL;
					put_byte(CH_PCT);
					put_byte(held);
					feed_plain(b);
				end
			end
			default: begin
				esc_ph = PH_NORMAL;
				feed_plain(b);
			end
		endcase
		if (l) begin
			// escape cut off by the end of the string goes out literally
			if (esc_ph == PH_PCT) begin
				put_byte(CH_PCT);
			end else if (esc_ph == PH_DIGIT) begin
				put_byte(CH_PCT);
				put_byte(held);
			end
			r = '0;
			r.se = 1'b1;
			r.len = emitted;
			step_out.push_back(r);
			esc_ph = PH_NORMAL;
			held = 8'h00;
			emitted = '0;
		end
		if (step_out.size() > 0) begin
			step_out[step_out.size() - 1].rl = 1'b1;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] rand_hex();
		logic [7:0] v;
		v = 8'($urandom_range(0, 15));
		if (v < 10) return CH_ZERO + v;
		return ($urandom_range(0, 1) ? CH_UA : CH_LA) + v - 8'd10;
	endfunction

	function automatic logic [7:0] rand_nonhex();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (hex_val(c) >= 0);
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_cnt++;
	endtask

	task automatic check_result();
		dec_result_t e;
		if (pending_out.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with nothing expected", n_results));
		end else begin
			e = pending_out.pop_front();
			if (out_byte !== e.ob)
				report_mismatch($sformatf("result %0d out_byte %0h, want %0h",
					n_results, out_byte, e.ob));
			if (has_byte !== e.hb)
				report_mismatch($sformatf("result %0d has_byte %0b, want %0b",
					n_results, has_byte, e.hb));
			if (run_last !== e.rl)
				report_mismatch($sformatf("result %0d run_last %0b, want %0b",
					n_results, run_last, e.rl));
			if (string_end !== e.se)
				report_mismatch($sformatf("result %0d string_end %0b, want %0b",
					n_results, string_end, e.se));
			if (decoded_length !== e.len)
				report_mismatch($sformatf("result %0d decoded_length %0d, want %0d",
					n_results, decoded_length, e.len));
		end
		n_results++;
	endtask

	// offer one byte, hold it until the transfer, then predict its results
	task automatic send_item(input logic [7:0] b, input logic l, input bit typed,
			input logic [7:0] eb);
		int gap;
		dec_result_t r;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		in_byte <= b;
		in_last <= l;
		do begin
			@(posedge clk);
			if (full) n_full_stalls++;
		end while (full);
		decode_step(b, l);
		if (typed) begin
			r = '0;
			r.ob = eb;
			r.hb = 1'b1;
			r.rl = 1'b1;
			pending_out.push_back(r);
		end else begin
			foreach (step_out[i]) pending_out.push_back(step_out[i]);
		end
		n_items++;
		if (l) n_strings++;
	endtask

	// limit changes only between strings with the decoder drained
	task automatic set_limit(input logic [LIMIT_W-1:0] v);
		push <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_q = v;
		n_cfg++;
	endtask

	// mostly well formed text with escapes, some broken escapes and raw noise
	task automatic send_random_string();
		logic [7:0] s[$];
		int ntok;
		int r;
		ntok = $urandom_range(1, 6);
		for (int t = 0; t < ntok; t++) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				s.push_back(8'($urandom_range(8'h20, 8'h7E)));
			end else if (r < 45) begin
				s.push_back(CH_PLUS);
			end else if (r < 75) begin
				s.push_back(CH_PCT);
				s.push_back(rand_hex());
				s.push_back(rand_hex());
			end else if (r < 80) begin
				s.push_back(CH_PCT);
				s.push_back(rand_nonhex());
			end else if (r < 85) begin
				s.push_back(CH_PCT);
				s.push_back(rand_hex());
				s.push_back(rand_nonhex());
			end else if (r < 95) begin
				s.push_back(8'($urandom_range(0, 255)));
			end else begin
				s.push_back(CH_PCT);
			end
		end
		foreach (s[i]) send_item(s[i], (i == s.size() - 1), 1'b0, 8'h00);
	endtask

	// result side
	initial begin
		int hold_cnt;
		int gap_cnt;
		hold_cnt = 0;
		gap_cnt  = 0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) check_result();
			if (stall_req) begin
				stall_req = 1'b0;
				hold_cnt  = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				pop <= 1'b0;
			end else if (gap_cnt > 0) begin
				gap_cnt--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 3) == 0) gap_cnt = pick_gap();
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int idle_cnt;
		idle_cnt = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) begin
				idle_cnt = 0;
			end else begin
				idle_cnt++;
			end
			if (idle_cnt >= WATCHDOG_CYCLES) begin
				$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
					idle_cnt, pending_out.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int p;
		int nstr;
		int r;
		logic [LIMIT_W-1:0] lim;
		err_cnt       = 0;
		n_items       = 0;
		n_strings     = 0;
		n_results     = 0;
		n_cfg         = 0;
		n_full_stalls = 0;
		no_idle       = 1'b0;
		stall_req     = 1'b0;
		esc_ph        = PH_NORMAL;
		held          = 8'h00;
		emitted       = '0;
		limit_q       = LIMIT_RESET;
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		push        <= 1'b0;
		in_byte     <= 8'h00;
		in_last     <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].eb);

		p = 0;
		while (n_items < TARGET_ITEMS) begin
			case (p)
				0: lim = 17'd1;
				1: lim = 17'd0;
				2: lim = 17'h1FFFF;
				3: lim = 17'd2;
				4: lim = LIMIT_RESET;
				default: begin
					r = $urandom_range(0, 3);
					if (r == 0)      lim = 17'($urandom_range(1, 12));
					else if (r == 1) lim = 17'($urandom_range(0, 17'h1FFFF));
					else if (r == 2) lim = LIMIT_RESET;
					else             lim = 17'($urandom_range(0, 4));
				end
			endcase
			set_limit(lim);
			nstr = $urandom_range(2, 5);
			no_idle = 1'b0;
			if (p == 2) begin
				// long receiver hold while bytes keep coming, so the queue fills
				stall_req = 1'b1;
				no_idle   = 1'b1;
				nstr      = 6;
			end else if (p == 3) begin
				no_idle = 1'b1;
			end
			for (int k = 0; k < nstr; k++) send_random_string();
			p++;
		end
		no_idle = 1'b0;

		push <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("run: %0d bytes in %0d strings, %0d results checked", n_items, n_strings,
			n_results);
		$display("     %0d limit settings, %0d cycles of input held off by full", n_cfg,
			n_full_stalls);
		if (err_cnt == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
